### rtl/qpe_pkg.sv
// Shared types, constants and helpers for the quoted-printable encoder.
package qpe_pkg;

  localparam int MaxRes = 9;
  localparam int CountW = 4;

  localparam logic [7:0] LimitReset = 8'd72;

  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChEq    = 8'h3d;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChTwo   = 8'h32;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] LenMax  = 8'hff;
  localparam logic [3:0] NibbleMask = 4'hf;

  typedef struct packed {
    logic [7:0] line_length;
    logic       blank_held;
    logic       blank_is_tab;
    logic       cr_held;
  } qpe_state_t;

  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    logic [CountW-1:0]      count;
  } qpe_result_t;

  // Upper-case hex digit for a nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = 8'h30 + {4'h0, nib};
    end else begin
      d = 8'h37 + {4'h0, nib};
    end
    return d;
  endfunction

endpackage

### rtl/qpe_encode.sv
// Combinational encoder: one input word plus state to up to nine output bytes.
module qpe_encode import qpe_pkg::*; (
  input  logic [7:0]  in_byte,
  input  logic        is_last,
  input  logic [7:0]  limit,
  input  qpe_state_t  st,
  output qpe_result_t res,
  output qpe_state_t  st_next
);

  logic [MaxRes-1:0][7:0] ob;
  logic [CountW-1:0]      n;
  logic [7:0]             ll;
  logic                   bh;
  logic                   bt;
  logic                   ch;
  logic                   consumed;
  logic                   printable;
  logic [8:0]             len_sum;
  logic [7:0]             blank_ch;

  assign printable = (in_byte > 8'd32) && (in_byte < 8'd127) && (in_byte != ChEq);

  always_comb begin
    ob       = '0;
    n        = '0;
    ll       = st.line_length;
    bh       = st.blank_held;
    bt       = st.blank_is_tab;
    ch       = st.cr_held;
    consumed = 1'b0;
    len_sum  = '0;
    blank_ch = st.blank_is_tab ? ChTab : ChSpace;

    // held CR resolves first
    if (ch) begin
      ob[n] = ChCr; n = n + 1'b1;
      ob[n] = ChLf; n = n + 1'b1;
      ch = 1'b0;
      ll = '0;
      if (in_byte == ChLf) consumed = 1'b1;
    end

    if (!consumed) begin
      if (in_byte == ChCr) begin
        if (bh) begin
          ob[n] = ChEq;                 n = n + 1'b1;
          ob[n] = bt ? ChZero : ChTwo;  n = n + 1'b1;
          ob[n] = bt ? ChNine : ChZero; n = n + 1'b1;
          bh = 1'b0;
        end
        ch = 1'b1;
        ll = '0;
        consumed = 1'b1;
      end else if (in_byte == ChLf) begin
        if (bh) begin
          ob[n] = ChEq;                 n = n + 1'b1;
          ob[n] = bt ? ChZero : ChTwo;  n = n + 1'b1;
          ob[n] = bt ? ChNine : ChZero; n = n + 1'b1;
          bh = 1'b0;
        end
        ob[n] = ChCr; n = n + 1'b1;
        ob[n] = ChLf; n = n + 1'b1;
        ll = '0;
        consumed = 1'b1;
      end else if (ll > limit) begin
        if (bh && printable) begin
          // printable byte pulled onto the line behind the blank
          ob[n] = blank_ch; n = n + 1'b1;
          bh = 1'b0;
          ob[n] = in_byte;  n = n + 1'b1;
          ob[n] = ChEq;     n = n + 1'b1;
          ob[n] = ChCr;     n = n + 1'b1;
          ob[n] = ChLf;     n = n + 1'b1;
          ll = '0;
          consumed = 1'b1;
        end else begin
          if (bh) begin
            ob[n] = ChEq;                 n = n + 1'b1;
            ob[n] = bt ? ChZero : ChTwo;  n = n + 1'b1;
            ob[n] = bt ? ChNine : ChZero; n = n + 1'b1;
            bh = 1'b0;
          end
          ob[n] = ChEq; n = n + 1'b1;
          ob[n] = ChCr; n = n + 1'b1;
          ob[n] = ChLf; n = n + 1'b1;
          ll = '0;
        end
      end else if (bh) begin
        ob[n] = blank_ch; n = n + 1'b1;
        bh = 1'b0;
      end
    end

    if (!consumed) begin
      if ((ll == 8'd0) && (in_byte == ChDot)) begin
        ob[n] = ChDot; n = n + 1'b1;
        ob[n] = ChDot; n = n + 1'b1;
        ll = 8'd1;
      end else if ((in_byte == ChSpace) || (in_byte == ChTab)) begin
        bh = 1'b1;
        bt = (in_byte == ChTab);
        len_sum = {1'b0, ll} + 9'd1;
        ll = len_sum[8] ? LenMax : len_sum[7:0];
      end else if ((in_byte < 8'd32) || (in_byte == ChEq) || (in_byte > 8'd126)) begin
        ob[n] = ChEq;                                 n = n + 1'b1;
        ob[n] = hex_digit(in_byte[7:4] & NibbleMask); n = n + 1'b1;
        ob[n] = hex_digit(in_byte[3:0] & NibbleMask); n = n + 1'b1;
        len_sum = {1'b0, ll} + 9'd3;
        ll = len_sum[8] ? LenMax : len_sum[7:0];
      end else begin
        ob[n] = in_byte; n = n + 1'b1;
        len_sum = {1'b0, ll} + 9'd1;
        ll = len_sum[8] ? LenMax : len_sum[7:0];
      end
    end

    // message end flushes whatever is held
    if (is_last) begin
      if (bh) begin
        ob[n] = ChEq;                 n = n + 1'b1;
        ob[n] = bt ? ChZero : ChTwo;  n = n + 1'b1;
        ob[n] = bt ? ChNine : ChZero; n = n + 1'b1;
      end
      if (ch) begin
        ob[n] = ChCr; n = n + 1'b1;
        ob[n] = ChLf; n = n + 1'b1;
      end
      ll = '0;
      bh = 1'b0;
      bt = 1'b0;
      ch = 1'b0;
    end

    res.bytes            = ob;
    res.count            = n;
    st_next.line_length  = ll;
    st_next.blank_held   = bh;
    st_next.blank_is_tab = bt;
    st_next.cr_held      = ch;
  end

endmodule

### rtl/quoted_printable_encoder.sv
// Quoted-printable body encoder with SMTP dot-stuffing, top level.
//
// Each accepted input word (one body byte plus an end-of-message flag) is
// encoded in the cycle it is accepted into a result buffer of up to nine
// bytes, which then leaves one byte per cycle on the output channel while
// out_stall is low. The next word is taken in the same cycle as the last of
// those bytes, so the single output byte port sets the word rate; a new word
// is not taken before the last byte of the current buffer is taken. Words
// that only update state (a held space, tab or CR) emit nothing. run_end
// marks the last byte caused by a word, message_end the last byte of a
// message. The soft break limit is written through cfg_we / cfg_data while
// the block is idle; the user is bound to this, the block itself does not
// enforce it. The limit resets to 72.
module quoted_printable_encoder import qpe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_end,
  output logic       message_end
);

  // encoder state and configuration
  logic [7:0]  limit;
  qpe_state_t  st;
  qpe_state_t  st_next;
  qpe_result_t enc_res;

  // result buffer
  logic [MaxRes-1:0][7:0] obuf;
  logic [CountW-1:0]      cnt;
  logic [CountW-1:0]      ptr;
  logic                   msg_last;
  logic                   busy;

  logic accept;
  logic take;
  logic final_take;

  qpe_encode u_enc (
    .in_byte (in_byte),
    .is_last (is_last),
    .limit   (limit),
    .st      (st),
    .res     (enc_res),
    .st_next (st_next)
  );

  // Output side: a byte leaves when not stalled; the buffer frees up on its
  // last byte, so a new word can load in that same cycle.
  assign out_valid   = busy;
  assign out_byte    = obuf[ptr];
  assign run_end     = (ptr == cnt - 1'b1);
  assign message_end = run_end && msg_last;

  assign take       = out_valid && !out_stall;
  assign final_take = take && run_end;
  assign in_stall   = busy && !final_take;
  assign accept     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LimitReset;
    end else if (cfg_we) begin
      limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ptr  <= '0;
      cnt  <= '0;
    end else if (accept && (enc_res.count != '0)) begin
      busy <= 1'b1;
      ptr  <= '0;
      cnt  <= enc_res.count;
    end else if (final_take) begin
      busy <= 1'b0;
      ptr  <= '0;
    end else if (take) begin
      ptr <= ptr + 1'b1;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept && (enc_res.count != '0)) begin
      obuf     <= enc_res.bytes;
      msg_last <= is_last;
    end
  end

`ifndef NO_ASSERTIONS
  // a loaded buffer always holds at least one byte and the pointer stays in it
  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> ((cnt != '0) && (ptr < cnt)))
    else $error("result pointer outside buffer");

  // the buffer is only refilled once its last byte is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (accept && busy) |-> final_take)
    else $error("input accepted over pending results");

  // message end only on the final byte of a word
  a_msg_end_run_end: assert property (@(posedge clk) disable iff (rst)
    message_end |-> run_end)
    else $error("message_end without run_end");

  // after the last byte with nothing new loaded, the output goes idle
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (final_take && !accept) |=> !out_valid)
    else $error("output still valid after buffer drained");
`endif

endmodule
